// ===== design/text_console_char_writer_assert.svh =====
// ----------------------------------------------------------------------------
// text_console_char_writer_assert
// assertion macros of the console writer top level
// ----------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_CHAR_WRITER_ASSERT_SVH
`define TEXT_CONSOLE_CHAR_WRITER_ASSERT_SVH

// same-cycle implication
`define TCCW_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define TCCW_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/tccw_pkg.sv =====
// ----------------------------------------------------------------------------
// tccw_pkg
// screen geometry, cell codes and shared types of the console writer
// ----------------------------------------------------------------------------
`default_nettype none

package tccw_pkg;

  localparam int COLUMNS    = 80;
  localparam int ROWS       = 25;
  localparam int CELL_COUNT = COLUMNS * ROWS;
  localparam int MOVE_COUNT = COLUMNS * (ROWS - 1);
  localparam int ADDR_W     = $clog2(CELL_COUNT);
  localparam int COL_W      = $clog2(COLUMNS);
  localparam int LINE_W     = $clog2(ROWS);
  localparam int COLX_W     = COL_W + 1;
  localparam int LINEX_W    = LINE_W + 1;
  localparam int CELL_W     = 16;

  typedef logic [ADDR_W-1:0]  addr_t;
  typedef logic [COL_W-1:0]   col_t;
  typedef logic [LINE_W-1:0]  line_t;
  typedef logic [COLX_W-1:0]  colx_t;
  typedef logic [LINEX_W-1:0] linex_t;
  typedef logic [CELL_W-1:0]  cell_t;

  localparam logic [7:0] BLANK_CHAR = 8'h20;
  localparam logic [7:0] RESET_ATTR = 8'h0F;
  localparam logic [7:0] CH_NL      = 8'h0A;
  localparam logic [7:0] CH_CR      = 8'h0D;
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_BS      = 8'h08;

  typedef enum logic [1:0] {
    CMD_PUT    = 2'd0,
    CMD_PUT_AT = 2'd1,
    CMD_CLEAR  = 2'd2,
    CMD_READ   = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_INIT_WAIT,
    ST_IDLE,
    ST_EXEC,
    ST_READ,
    ST_SWEEP,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic  we;
    addr_t waddr;
    cell_t wdata;
    logic  re;
    addr_t raddr;
  } mem_req_t;

  typedef struct packed {
    logic       start;
    logic       scroll;
    logic [7:0] attr;
  } sweep_cmd_t;

  typedef struct packed {
    logic busy;
    logic done;
  } sweep_stat_t;

  typedef struct packed {
    line_t line;
    col_t  column;
    logic  scroll;
    logic  we;
    addr_t waddr;
    cell_t wdata;
  } cursor_upd_t;

  function automatic addr_t cell_addr(line_t l, col_t c);
    return addr_t'(l) * addr_t'(COLUMNS) + addr_t'(c);
  endfunction

endpackage

`default_nettype wire

// ===== design/tccw_ram.sv =====
// ----------------------------------------------------------------------------
// tccw_ram
// generic simple dual-port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module tccw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== design/tccw_cursor.sv =====
// ----------------------------------------------------------------------------
// tccw_cursor
// character interpreter: next cursor, cell write and scroll request
// ----------------------------------------------------------------------------
`default_nettype none

module tccw_cursor (
  input  tccw_pkg::line_t     line,
  input  tccw_pkg::col_t      column,
  input  logic [7:0]          ch,
  input  logic [7:0]          attr,
  output tccw_pkg::cursor_upd_t upd
);

  tccw_pkg::addr_t  here;
  tccw_pkg::colx_t  col_x;
  tccw_pkg::colx_t  tab_sum;
  tccw_pkg::linex_t line_x;

  always_comb begin
    here    = tccw_pkg::cell_addr(line, column);
    col_x   = {1'b0, column};
    line_x  = {1'b0, line};
    tab_sum = col_x + tccw_pkg::colx_t'(8);
    upd       = '0;
    upd.waddr = here;
    upd.wdata = {attr, ch};
    case (ch)
      tccw_pkg::CH_NL: begin
        col_x  = '0;
        line_x = line_x + 1'b1;
      end
      tccw_pkg::CH_CR: begin
        col_x = '0;
      end
      tccw_pkg::CH_TAB: begin
        col_x = {tab_sum[tccw_pkg::COLX_W-1:3], 3'b000};
      end
      tccw_pkg::CH_BS: begin
        // never leaves column 0
        if (column != '0) begin
          col_x     = col_x - 1'b1;
          upd.we    = 1'b1;
          upd.waddr = here - 1'b1;
          upd.wdata = {attr, tccw_pkg::BLANK_CHAR};
        end
      end
      default: begin
        upd.we = 1'b1;
        col_x  = col_x + 1'b1;
      end
    endcase
    // wrap at right edge
    if (col_x >= tccw_pkg::colx_t'(tccw_pkg::COLUMNS)) begin
      col_x  = '0;
      line_x = line_x + 1'b1;
    end
    // past the bottom line
    if (line_x >= tccw_pkg::linex_t'(tccw_pkg::ROWS)) begin
      upd.scroll = 1'b1;
      line_x     = tccw_pkg::linex_t'(tccw_pkg::ROWS - 1);
    end
    upd.line   = line_x[tccw_pkg::LINE_W-1:0];
    upd.column = col_x[tccw_pkg::COL_W-1:0];
  end

endmodule

`default_nettype wire

// ===== design/tccw_sweep.sv =====
// ----------------------------------------------------------------------------
// tccw_sweep
// screen walker: scroll up one line or blank every cell, one cell a cycle
// ----------------------------------------------------------------------------
`default_nettype none

module tccw_sweep (
  input  logic                  clk,
  input  logic                  rst,
  input  tccw_pkg::sweep_cmd_t  cmd,
  input  tccw_pkg::cell_t       rdata,
  output tccw_pkg::sweep_stat_t stat,
  output tccw_pkg::mem_req_t    mem
);

  logic            active;
  logic            scroll;
  logic [7:0]      attr;
  tccw_pkg::addr_t idx;
  logic            copy_now;
  logic            pend_valid;
  logic            pend_copy;
  tccw_pkg::addr_t pend_addr;

  // cells below the first line are moved up, the last line is blanked
  assign copy_now = scroll && (idx < tccw_pkg::addr_t'(tccw_pkg::MOVE_COUNT));

  always_ff @(posedge clk) begin
    if (rst) begin
      active     <= 1'b0;
      pend_valid <= 1'b0;
    end else begin
      pend_valid <= active;
      if (cmd.start) begin
        active <= 1'b1;
      end else if (active && idx == tccw_pkg::addr_t'(tccw_pkg::CELL_COUNT - 1)) begin
        active <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      idx    <= '0;
      scroll <= cmd.scroll;
      attr   <= cmd.attr;
    end else if (active) begin
      idx <= idx + 1'b1;
    end
    pend_addr <= idx;
    pend_copy <= copy_now;
  end

  always_comb begin
    mem.re    = active && copy_now;
    mem.raddr = idx + tccw_pkg::addr_t'(tccw_pkg::COLUMNS);
    mem.we    = pend_valid;
    mem.waddr = pend_addr;
    mem.wdata = pend_copy ? rdata : {attr, tccw_pkg::BLANK_CHAR};
    stat.busy = active || pend_valid;
    stat.done = pend_valid && !active;
  end

endmodule

`default_nettype wire

// ===== design/text_console_char_writer.sv =====
// put char, put at position: accept, then the exec and done states, then the result beat
// read cell: accept, then the exec, read and done states (one registered read of the screen ram)
// scroll and clear walk the screen ram one cell a cycle
// one item in flight; the next item can be taken in the cycle after the result is staged
// reset: cursor homed, attribute 0x0F, then a blanking pass writes every cell
// to 0x0F20 while in_ready stays low (cfg taken always)
// ----------------------------------------------------------------------------
// text_console_char_writer
// text screen in a single ram with cursor, scroll, clear and cell access
// ----------------------------------------------------------------------------
`default_nettype none

module text_console_char_writer (
  input  logic        clk,
  input  logic        rst,
  // command channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  cmd,
  input  logic [7:0]  ch,
  input  logic [4:0]  row,
  input  logic [6:0]  col,
  input  logic [7:0]  attr,
  // result channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic [4:0]  cursor_line_out,
  output logic [6:0]  cursor_column_out,
  output logic [11:0] cursor_offset,
  output logic [7:0]  cell_char,
  output logic [7:0]  cell_attr,
  output logic        scrolled,
  // attribute register write
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data
);

`include "text_console_char_writer_assert.svh"

  tccw_pkg::state_t state, state_next;

  // cursor and attribute
  tccw_pkg::line_t cur_line, cur_line_next;
  tccw_pkg::col_t  cur_column, cur_column_next;
  logic [7:0]      text_attribute;

  // captured command beat
  tccw_pkg::cmd_t  op_cmd;
  logic [7:0]      op_ch;
  logic [4:0]      op_row;
  logic [6:0]      op_col;
  logic [7:0]      op_attr;

  tccw_pkg::cell_t rd_cell;
  logic            did_scroll, did_scroll_next;
  logic            in_range;
  tccw_pkg::addr_t pos;
  logic            load_out;

  tccw_pkg::cursor_upd_t upd;
  tccw_pkg::sweep_cmd_t  sw_cmd;
  tccw_pkg::sweep_stat_t sw_stat;
  tccw_pkg::mem_req_t    sw_mem, op_mem, mem;
  tccw_pkg::cell_t       rdata;

  assign in_ready  = (state == tccw_pkg::ST_IDLE);
  assign cfg_ready = 1'b1;

  // target position of put-at and read
  assign in_range = ({1'b0, op_row} < 6'(tccw_pkg::ROWS)) &&
                    ({1'b0, op_col} < 8'(tccw_pkg::COLUMNS));
  assign pos = tccw_pkg::cell_addr(tccw_pkg::line_t'(op_row), tccw_pkg::col_t'(op_col));

  tccw_cursor u_cursor (
    .line   (cur_line),
    .column (cur_column),
    .ch     (op_ch),
    .attr   (text_attribute),
    .upd    (upd)
  );

  tccw_sweep u_sweep (
    .clk   (clk),
    .rst   (rst),
    .cmd   (sw_cmd),
    .rdata (rdata),
    .stat  (sw_stat),
    .mem   (sw_mem)
  );

  // the walker owns the ram while it runs
  assign mem = sw_stat.busy ? sw_mem : op_mem;

  tccw_ram #(
    .WIDTH (tccw_pkg::CELL_W),
    .DEPTH (tccw_pkg::CELL_COUNT)
  ) u_screen (
    .clk   (clk),
    .we    (mem.we),
    .waddr (mem.waddr),
    .wdata (mem.wdata),
    .re    (mem.re),
    .raddr (mem.raddr),
    .rdata (rdata)
  );

  // next state, ram access of single-cell commands, walker start
  always_comb begin
    state_next      = state;
    cur_line_next   = cur_line;
    cur_column_next = cur_column;
    did_scroll_next = did_scroll;
    op_mem          = '0;
    sw_cmd          = '0;
    load_out        = 1'b0;
    case (state)
      tccw_pkg::ST_INIT: begin
        // power-up blanking uses the reset attribute, not the register
        sw_cmd.start = 1'b1;
        sw_cmd.attr  = tccw_pkg::RESET_ATTR;
        state_next   = tccw_pkg::ST_INIT_WAIT;
      end
      tccw_pkg::ST_INIT_WAIT: begin
        if (sw_stat.done) begin
          state_next = tccw_pkg::ST_IDLE;
        end
      end
      tccw_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_next = tccw_pkg::ST_EXEC;
        end
      end
      tccw_pkg::ST_EXEC: begin
        did_scroll_next = 1'b0;
        state_next      = tccw_pkg::ST_DONE;
        case (op_cmd)
          tccw_pkg::CMD_PUT: begin
            // cell write lands before the walker's first read
            op_mem.we       = upd.we;
            op_mem.waddr    = upd.waddr;
            op_mem.wdata    = upd.wdata;
            cur_line_next   = upd.line;
            cur_column_next = upd.column;
            did_scroll_next = upd.scroll;
            if (upd.scroll) begin
              sw_cmd.start  = 1'b1;
              sw_cmd.scroll = 1'b1;
              sw_cmd.attr   = text_attribute;
              state_next    = tccw_pkg::ST_SWEEP;
            end
          end
          tccw_pkg::CMD_PUT_AT: begin
            op_mem.we    = in_range;
            op_mem.waddr = pos;
            op_mem.wdata = {op_attr, op_ch};
          end
          tccw_pkg::CMD_CLEAR: begin
            cur_line_next   = '0;
            cur_column_next = '0;
            sw_cmd.start    = 1'b1;
            sw_cmd.attr     = text_attribute;
            state_next      = tccw_pkg::ST_SWEEP;
          end
          tccw_pkg::CMD_READ: begin
            op_mem.re    = in_range;
            op_mem.raddr = pos;
            state_next   = tccw_pkg::ST_READ;
          end
          default: begin
            state_next = tccw_pkg::ST_DONE;
          end
        endcase
      end
      tccw_pkg::ST_READ: begin
        state_next = tccw_pkg::ST_DONE;
      end
      tccw_pkg::ST_SWEEP: begin
        if (sw_stat.done) begin
          state_next = tccw_pkg::ST_DONE;
        end
      end
      tccw_pkg::ST_DONE: begin
        // wait here only while the previous result beat is still held
        if (!out_valid || out_ready) begin
          load_out   = 1'b1;
          state_next = tccw_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = tccw_pkg::ST_INIT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= tccw_pkg::ST_INIT;
      cur_line       <= '0;
      cur_column     <= '0;
      text_attribute <= tccw_pkg::RESET_ATTR;
      did_scroll     <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      state      <= state_next;
      cur_line   <= cur_line_next;
      cur_column <= cur_column_next;
      did_scroll <= did_scroll_next;
      if (cfg_valid && cfg_ready) begin
        text_attribute <= cfg_data;
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      op_cmd  <= tccw_pkg::cmd_t'(cmd);
      op_ch   <= ch;
      op_row  <= row;
      op_col  <= col;
      op_attr <= attr;
    end
    if (state == tccw_pkg::ST_READ) begin
      rd_cell <= in_range ? rdata : '0;
    end
    if (load_out) begin
      cursor_line_out   <= 5'(cur_line);
      cursor_column_out <= 7'(cur_column);
      cursor_offset     <= 12'(tccw_pkg::cell_addr(cur_line, cur_column));
      cell_char         <= (op_cmd == tccw_pkg::CMD_READ) ? rd_cell[7:0] : 8'h00;
      cell_attr         <= (op_cmd == tccw_pkg::CMD_READ) ? rd_cell[15:8] : 8'h00;
      scrolled          <= did_scroll;
    end
  end

  // an accepted beat always goes straight to execution
  `TCCW_ASSERT_NXT(a_accept_exec, clk, rst, in_valid && in_ready, state == tccw_pkg::ST_EXEC, "accepted beat did not execute")
  // no command is taken while the walker owns the ram
  `TCCW_ASSERT_IMP(a_sweep_blocks, clk, rst, sw_stat.busy, !in_ready, "command taken during sweep")
  // cursor line stays on screen
  `TCCW_ASSERT_IMP(a_line_range, clk, rst, 1'b1, cur_line < tccw_pkg::line_t'(tccw_pkg::ROWS), "cursor line off screen")
  // a result beat is staged only from the done state
  `TCCW_ASSERT_IMP(a_out_from_done, clk, rst, $rose(out_valid), $past(state) == tccw_pkg::ST_DONE, "result staged outside done")

endmodule

`default_nettype wire

// ===== dv/text_console_char_writer_tb.sv =====
// ----------------------------------------------------------------------------
// text_console_char_writer_tb
// checks the console writer against a cycle-free model of its screen and cursor
// short directed table over control characters, edge positions, scroll and clear
// then random traffic in phases, each with its own text attribute,
// under random stalls on both channels, except in one burst phase
// ----------------------------------------------------------------------------

module text_console_char_writer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tccw_pkg::*;

  localparam int RANDOM_PHASES = 10;
  localparam int PHASE_ITEMS   = 150;
  localparam int HOLD_AT       = 300;   // result count at which the sink holds off
  localparam int HOLD_CYCLES   = 600;
  localparam int DRAIN_CYCLES  = 64;

  // one command beat
  typedef struct packed {
    cmd_t       op;
    logic [7:0] ch;
    logic [4:0] row;
    logic [6:0] col;
    logic [7:0] attr;
  } console_item_t;

  // one result beat
  typedef struct packed {
    logic [4:0]  line;
    logic [6:0]  column;
    logic [11:0] offset;
    logic [7:0]  cell_char;
    logic [7:0]  cell_attr;
    logic        scrolled;
  } cursor_report_t;

  // a directed step, repeated reps times; typed rows carry a hand-written result
  typedef struct {
    console_item_t  item;
    int             reps;
    bit             typed;
    cursor_report_t want;
  } plan_row_t;

  // dut ports, all inputs known from time zero
  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        in_valid  = 1'b0;
  logic        in_ready;
  logic [1:0]  cmd       = '0;
  logic [7:0]  ch        = '0;
  logic [4:0]  row       = '0;
  logic [6:0]  col       = '0;
  logic [7:0]  attr      = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [4:0]  cursor_line_out;
  logic [6:0]  cursor_column_out;
  logic [11:0] cursor_offset;
  logic [7:0]  cell_char;
  logic [7:0]  cell_attr;
  logic        scrolled;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [7:0]  cfg_data  = '0;

  // model of the screen, the cursor and the attribute register
  logic [15:0] screen_mem [CELL_COUNT];
  int          cur_line_m;
  int          cur_col_m;
  logic [7:0]  text_attr_m;

  // results owed by the dut, oldest first
  cursor_report_t due_reports [$];
  cursor_report_t head_report;

  int  mismatches    = 0;
  int  results_seen  = 0;
  int  scroll_count  = 0;
  int  attr_writes   = 0;
  int  op_count [4]  = '{default: 0};
  bit  burst_mode    = 1'b0;   // no idling on either side while set
  bit  hold_done     = 1'b0;

  text_console_char_writer dut (
    .clk               (clk),
    .rst               (rst),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .cmd               (cmd),
    .ch                (ch),
    .row               (row),
    .col               (col),
    .attr              (attr),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .cursor_line_out   (cursor_line_out),
    .cursor_column_out (cursor_column_out),
    .cursor_offset     (cursor_offset),
    .cell_char         (cell_char),
    .cell_attr         (cell_attr),
    .scrolled          (scrolled),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_data          (cfg_data)
  );

  always #5 clk = ~clk;

  // --------------------------------------------------------------------------
  // screen model: applies one command, returns the result beat it should cause
  // --------------------------------------------------------------------------
  function automatic cursor_report_t screen_apply(console_item_t it);
    cursor_report_t rep;
    int             here;
    int             pos;
    bit             in_range;
    rep      = '0;
    in_range = (int'(it.row) < ROWS) && (int'(it.col) < COLUMNS);
    pos      = int'(it.row) * COLUMNS + int'(it.col);
    case (it.op)
      CMD_PUT: begin
        here = cur_line_m * COLUMNS + cur_col_m;
        if (it.ch == CH_NL) begin
          cur_col_m = 0;
          cur_line_m++;
        end else if (it.ch == CH_CR) begin
          cur_col_m = 0;
        end else if (it.ch == CH_TAB) begin
          // next multiple of eight
          cur_col_m = (cur_col_m + 8) & ~7;
        end else if (it.ch == CH_BS) begin
          // backspace blanks the cell to the left, stuck at column zero
          if (cur_col_m > 0) begin
            cur_col_m--;
            screen_mem[here - 1] = {text_attr_m, BLANK_CHAR};
          end
        end else begin
          // any other byte lands as is, high bytes included
          screen_mem[here] = {text_attr_m, it.ch};
          cur_col_m++;
        end
        // right edge wraps to the next line
        if (cur_col_m >= COLUMNS) begin
          cur_col_m = 0;
          cur_line_m++;
        end
        // past the bottom: move everything up a line, blank the last one
        if (cur_line_m >= ROWS) begin
          for (int i = 0; i < CELL_COUNT - COLUMNS; i++)
            screen_mem[i] = screen_mem[i + COLUMNS];
          for (int i = CELL_COUNT - COLUMNS; i < CELL_COUNT; i++)
            screen_mem[i] = {text_attr_m, BLANK_CHAR};
          cur_line_m   = ROWS - 1;
          rep.scrolled = 1'b1;
        end
      end
      CMD_PUT_AT: begin
        // out of range positions are dropped
        if (in_range) screen_mem[pos] = {it.attr, it.ch};
      end
      CMD_CLEAR: begin
        for (int i = 0; i < CELL_COUNT; i++)
          screen_mem[i] = {text_attr_m, BLANK_CHAR};
        cur_line_m = 0;
        cur_col_m  = 0;
      end
      default: begin
        // read, zeros when out of range
        if (in_range) begin
          rep.cell_char = screen_mem[pos][7:0];
          rep.cell_attr = screen_mem[pos][15:8];
        end
      end
    endcase
    rep.line   = 5'(cur_line_m);
    rep.column = 7'(cur_col_m);
    rep.offset = 12'(cur_line_m * COLUMNS + cur_col_m);
    return rep;
  endfunction

  // idle length for either side: mostly none, often short, now and then long
  function automatic int idle_cycles();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 55) return 0;
    if (pick < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 60);
  endfunction

  // random command, biased toward cursor traffic so the screen fills and scrolls
  function automatic console_item_t random_item();
    console_item_t it;
    int            pick;
    it.ch   = 8'($urandom_range(0, 255));
    it.row  = 5'($urandom_range(0, 31));
    it.col  = 7'($urandom_range(0, 127));
    it.attr = 8'($urandom_range(0, 255));
    pick    = $urandom_range(0, 999);
    if (pick < 4)        it.op = CMD_CLEAR;
    else if (pick < 560) it.op = CMD_PUT;
    else if (pick < 760) it.op = CMD_PUT_AT;
    else                 it.op = CMD_READ;
    if (it.op == CMD_PUT) begin
      pick = $urandom_range(0, 99);
      if (pick < 14)      it.ch = CH_NL;
      else if (pick < 19) it.ch = CH_CR;
      else if (pick < 25) it.ch = CH_TAB;
      else if (pick < 34) it.ch = CH_BS;
    end else if (it.op == CMD_PUT_AT || it.op == CMD_READ) begin
      // mostly on screen, the rest anywhere the fields reach
      if ($urandom_range(0, 99) < 85) begin
        it.row = 5'($urandom_range(0, ROWS - 1));
        it.col = 7'($urandom_range(0, COLUMNS - 1));
      end
    end
    return it;
  endfunction

  function automatic plan_row_t plan_step(cmd_t op, logic [7:0] c, logic [4:0] r,
                                          logic [6:0] k, logic [7:0] a, int reps,
                                          bit typed, cursor_report_t want);
    plan_row_t p;
    p.item  = '{op: op, ch: c, row: r, col: k, attr: a};
    p.reps  = reps;
    p.typed = typed;
    p.want  = want;
    return p;
  endfunction

  // --------------------------------------------------------------------------
  // command channel: one beat, optional gap first, valid held until taken
  // --------------------------------------------------------------------------
  task automatic send_item(console_item_t it, bit typed, cursor_report_t want);
    int             gap;
    cursor_report_t modeled;
    gap = burst_mode ? 0 : idle_cycles();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    cmd      <= it.op;
    ch       <= it.ch;
    row      <= it.row;
    col      <= it.col;
    attr     <= it.attr;
    do @(posedge clk); while (!in_ready);
    // beat taken at this edge: model moves on, result is now owed
    modeled = screen_apply(it);
    due_reports.push_back(typed ? want : modeled);
    op_count[it.op]++;
    if (modeled.scrolled) scroll_count++;
  endtask

  // attribute register write, only issued with nothing in flight
  task automatic write_attribute(logic [7:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid   <= 1'b0;
    text_attr_m  = value;
    attr_writes++;
  endtask

  task automatic wait_drained();
    while (due_reports.size() != 0) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // result channel sink: random stalls plus one long hold-off under load
  // --------------------------------------------------------------------------
  initial begin : result_sink
    int stall;
    @(posedge clk);
    forever begin
      if (!hold_done && results_seen >= HOLD_AT) begin
        // long hold while the sender keeps offering, so the input backs up
        hold_done  = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        stall = burst_mode ? 0 : idle_cycles();
        if (stall == 0) begin
          out_ready <= 1'b1;
          @(posedge clk);
        end else begin
          out_ready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
    end
  end

  // four-state compare so unknown outputs count as mismatches
  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 'h%0h, actual 'h%0h", name, want, got);
      mismatches++;
    end
  endfunction

  // every result beat against the oldest owed result
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      results_seen++;
      if (due_reports.size() == 0) begin
        $error("result beat with no result owed");
        mismatches++;
      end else begin
        head_report = due_reports.pop_front();
        check_field("cursor_line_out",   head_report.line,      cursor_line_out);
        check_field("cursor_column_out", head_report.column,    cursor_column_out);
        check_field("cursor_offset",     head_report.offset,    cursor_offset);
        check_field("cell_char",         head_report.cell_char, cell_char);
        check_field("cell_attr",         head_report.cell_attr, cell_attr);
        check_field("scrolled",          head_report.scrolled,  scrolled);
      end
    end
  end

  // --------------------------------------------------------------------------
  // stimulus
  // --------------------------------------------------------------------------
  initial begin : stimulus
    plan_row_t      plan [$];
    cursor_report_t home_blank;
    cursor_report_t home_none;
    cursor_report_t no_report;
    logic [7:0]     phase_attr;

    // model after reset
    for (int i = 0; i < CELL_COUNT; i++) screen_mem[i] = {RESET_ATTR, BLANK_CHAR};
    cur_line_m  = 0;
    cur_col_m   = 0;
    text_attr_m = RESET_ATTR;

    home_blank = '{line: '0, column: '0, offset: '0, cell_char: BLANK_CHAR,
                   cell_attr: RESET_ATTR, scrolled: 1'b0};
    home_none  = '0;
    no_report  = '0;

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // reads of a fresh screen, corners and off-screen positions
    plan.push_back(plan_step(CMD_READ,   8'h00, 5'd0,  7'd0,   8'h00, 1, 1, home_blank));
    plan.push_back(plan_step(CMD_READ,   8'hFF, 5'd24, 7'd79,  8'hFF, 1, 1, home_blank));
    plan.push_back(plan_step(CMD_READ,   8'h00, 5'd31, 7'd127, 8'h00, 1, 1, home_none));
    plan.push_back(plan_step(CMD_READ,   8'h00, 5'd25, 7'd0,   8'h00, 1, 1, home_none));
    plan.push_back(plan_step(CMD_READ,   8'h00, 5'd0,  7'd80,  8'h00, 1, 1, home_none));
    // printable, high and zero bytes at the cursor
    plan.push_back(plan_step(CMD_PUT,    8'h41, 5'd0,  7'd0,   8'h00, 1, 0, no_report));
    plan.push_back(plan_step(CMD_PUT,    8'hFF, 5'd31, 7'd127, 8'hFF, 1, 0, no_report));
    plan.push_back(plan_step(CMD_PUT,    8'h80, 5'd0,  7'd0,   8'h00, 1, 0, no_report));
    plan.push_back(plan_step(CMD_PUT,    8'h00, 5'd0,  7'd0,   8'h00, 1, 0, no_report));
    // control characters, backspace in mid line and at column zero
    plan.push_back(plan_step(CMD_PUT,    CH_BS, 5'd0,  7'd0,   8'h00, 1, 0, no_report));
    plan.push_back(plan_step(CMD_PUT,    CH_TAB, 5'd0, 7'd0,   8'h00, 1, 0, no_report));
    plan.push_back(plan_step(CMD_PUT,    CH_CR, 5'd0,  7'd0,   8'h00, 1, 0, no_report));
    plan.push_back(plan_step(CMD_PUT,    CH_BS, 5'd0,  7'd0,   8'h00, 1, 0, no_report));
    // positioned writes at the corners and off screen
    plan.push_back(plan_step(CMD_PUT_AT, 8'hFF, 5'd24, 7'd79,  8'hFF, 1, 0, no_report));
    plan.push_back(plan_step(CMD_PUT_AT, 8'h00, 5'd0,  7'd0,   8'h00, 1, 0, no_report));
    plan.push_back(plan_step(CMD_PUT_AT, 8'h55, 5'd31, 7'd127, 8'hAA, 1, 0, no_report));
    plan.push_back(plan_step(CMD_PUT_AT, 8'h55, 5'd24, 7'd80,  8'hAA, 1, 0, no_report));
    plan.push_back(plan_step(CMD_READ,   8'h00, 5'd24, 7'd79,  8'h00, 1, 0, no_report));
    plan.push_back(plan_step(CMD_READ,   8'h00, 5'd0,  7'd0,   8'h00, 1, 0, no_report));
    // tab past the right edge, character wrap, then newlines down into a scroll
    plan.push_back(plan_step(CMD_PUT,    CH_TAB, 5'd0, 7'd0,   8'h00, 10, 0, no_report));
    plan.push_back(plan_step(CMD_PUT,    8'h78, 5'd0,  7'd0,   8'h00, 80, 0, no_report));
    plan.push_back(plan_step(CMD_PUT,    CH_NL, 5'd0,  7'd0,   8'h00, 24, 0, no_report));
    plan.push_back(plan_step(CMD_READ,   8'h00, 5'd24, 7'd0,   8'h00, 1, 0, no_report));
    // clear homes the cursor and blanks with the reset attribute
    plan.push_back(plan_step(CMD_CLEAR,  8'h00, 5'd0,  7'd0,   8'h00, 1, 1, home_none));
    plan.push_back(plan_step(CMD_READ,   8'h00, 5'd24, 7'd79,  8'h00, 1, 1, home_blank));

    foreach (plan[i])
      for (int r = 0; r < plan[i].reps; r++)
        send_item(plan[i].item, plan[i].typed, plan[i].want);
    in_valid <= 1'b0;
    wait_drained();

    // random phases, each under its own attribute: extremes first
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      if (p == 0)                      phase_attr = 8'h00;
      else if (p == 1)                 phase_attr = 8'hFF;
      else if (p == RANDOM_PHASES - 1) phase_attr = RESET_ATTR;
      else                             phase_attr = 8'($urandom_range(0, 255));
      write_attribute(phase_attr);
      // one phase runs flat out on both channels
      burst_mode = (p == 3);
      for (int k = 0; k < PHASE_ITEMS; k++)
        send_item(random_item(), 1'b0, no_report);
      in_valid <= 1'b0;
      wait_drained();
      burst_mode = 1'b0;
    end

    // room for any stray beat to show up
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d put, %0d put-at, %0d clear, %0d read commands, %0d scrolls",
             op_count[CMD_PUT], op_count[CMD_PUT_AT], op_count[CMD_CLEAR],
             op_count[CMD_READ], scroll_count);
    $display("%0d attribute settings, %0d results checked, %0d mismatches",
             attr_writes, results_seen, mismatches);
    if (mismatches == 0 && due_reports.size() == 0) begin
      $display("text_console_char_writer_tb passed");
    end else begin
      $display("text_console_char_writer_tb failed");
    end
    $finish;
  end

  // hang guard, well above the slowest legal run
  initial begin : watchdog
    #150ms;
    $display("text_console_char_writer_tb failed");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+design
design/tccw_pkg.sv
design/tccw_ram.sv
design/tccw_cursor.sv
design/tccw_sweep.sv
design/text_console_char_writer.sv
dv/text_console_char_writer_tb.sv
